// ----- hdl/mwsd_pkg.sv -----
// Package for the two-channel block mean / standard deviation block.
// Request and response payload types, control enums, constants and helpers.
// No dependencies.
`timescale 1ns / 1ps

package mwsd_pkg;

   // Request payload: one two-channel conversion
   typedef struct packed {
      logic signed [23:0] sample_ch0;
      logic signed [23:0] sample_ch1;
   } req_type;

   // Response payload: one block result
   typedef struct packed {
      logic signed [27:0] mean_ch0_mv;
      logic        [26:0] stddev_ch0_mv;
      logic signed [27:0] mean_ch1_mv;
      logic        [26:0] stddev_ch1_mv;
   } rsp_type;

   // Datapath widths
   localparam int WIDE_W = 84;   // products, quotients, radicand
   localparam int OPB_W  = 34;   // multiplier / divisor operand
   localparam int REM_W  = 45;   // remainder of divide and square root
   localparam int CNT_W  = 7;    // iteration counter

   // Iteration counts of the serial unit
   localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd34;
   localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd84;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd42;

   // Scaling constants
   localparam logic [OPB_W-1:0] MEAN_SCALE = 34'd150;
   localparam logic [OPB_W-1:0] STD_SCALE  = 34'd22500;
   localparam logic [26:0]      STD_MAX    = 27'h7FFFFFF;
   localparam logic [5:0]       MAX_COUNT  = 6'd32;

   // Register indexes
   localparam logic REG_OVERSAMPLE = 1'b0;
   localparam logic REG_SUBSAMPLES = 1'b1;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_OUT
   } st_type;

   typedef enum logic [3:0] {
      SP_SQ0,
      SP_SQ1,
      SP_MN_150,
      SP_MN_NK,
      SP_MN_DIV,
      SP_SD_NQ,
      SP_SD_S2,
      SP_SD_NUM,
      SP_SD_NKD,
      SP_SD_DEN,
      SP_SD_DIV,
      SP_SD_SQRT
   } step_type;

   // Zero acts as one, values above the maximum act as the maximum
   function automatic logic [5:0] eff_count(input logic [5:0] v);
      logic [5:0] r;
      if (v == 6'd0) r = 6'd1;
      else if (v > MAX_COUNT) r = MAX_COUNT;
      else r = v;
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] steps_for(input op_type op);
      logic [CNT_W-1:0] r;
      case (op)
         OP_MUL:  r = MUL_STEPS;
         OP_DIV:  r = DIV_STEPS;
         default: r = SQRT_STEPS;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/mwsd_serial.sv -----
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide,
// restoring integer square root, one result bit per cycle.
// Depends on mwsd_pkg.
`timescale 1ns / 1ps

module mwsd_serial (
   input  logic                       clock,
   input  logic                       reset,
   input  mwsd_pkg::cmd_type          cmd,
   input  logic [mwsd_pkg::WIDE_W-1:0] opa,
   input  logic [mwsd_pkg::OPB_W-1:0]  opb,
   output logic                       done,
   output logic [mwsd_pkg::WIDE_W-1:0] result
);
   import mwsd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   op_type            op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WIDE_W-1:0] x_ff, x_in;
   logic [OPB_W-1:0]  y_ff, y_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic [REM_W-1:0]  div_r, sq_r, sq_t;
   logic              div_ge, sq_ge;

   // One iteration step
   always_comb begin
      div_r  = {rem_ff[REM_W-2:0], x_ff[WIDE_W-1]};
      div_ge = div_r >= {{(REM_W-OPB_W){1'b0}}, y_ff};
      sq_r   = {rem_ff[REM_W-3:0], x_ff[WIDE_W-1 -: 2]};
      sq_t   = {1'b0, acc_ff[41:0], 2'b01};
      sq_ge  = sq_r >= sq_t;

      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = steps_for(cmd.op);
         x_in    = opa;
         y_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         unique case (op_ff)
            OP_MUL: begin
               if (y_ff[0]) acc_in = acc_ff + x_ff;
               x_in = {x_ff[WIDE_W-2:0], 1'b0};
               y_in = {1'b0, y_ff[OPB_W-1:1]};
            end
            OP_DIV: begin
               rem_in = div_ge ? div_r - {{(REM_W-OPB_W){1'b0}}, y_ff} : div_r;
               acc_in = {acc_ff[WIDE_W-2:0], div_ge};
               x_in   = {x_ff[WIDE_W-2:0], 1'b0};
            end
            default: begin
               rem_in = sq_ge ? sq_r - sq_t : sq_r;
               acc_in = {acc_ff[WIDE_W-2:0], sq_ge};
               x_in   = {x_ff[WIDE_W-3:0], 2'b00};
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ----- hdl/two_channel_block_mean_stddev.sv -----
// Two-channel block mean and sample standard deviation of ADC conversions.
// Requests are accepted while the sequencer is idle; a request that closes a sub-sample
// then holds off further requests during the two serial squarings of the channel sums.
// A block end then runs, per channel, up to 7 multiplies, two divides and a square root on
// the shared serial unit before the response is registered for output.
// Synchronous active-high reset clears sums and counters; oversample 15, sub-samples 20.
`timescale 1ns / 1ps

module two_channel_block_mean_stddev (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mwsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mwsd_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mwsd_pkg::*;

   // Configuration
   logic [5:0] k_cfg_ff, n_cfg_ff;

   // Control
   st_type     state_ff, state_in;
   step_type   step_ff, step_in;
   logic       ch_ff, ch_in;
   logic [5:0] conv_cnt_ff, conv_cnt_in;
   logic [5:0] sub_cnt_ff, sub_cnt_in;
   logic [5:0] k_lat_ff, k_lat_in;
   logic [5:0] n_lat_ff, n_lat_in;
   logic [5:0] n_blk_ff, n_blk_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Accumulators
   logic signed [28:0] acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic signed [33:0] sum0_ff, sum0_in, sum1_ff, sum1_in;
   logic [61:0]        sumsq0_ff, sumsq0_in, sumsq1_ff, sumsq1_in;

   // Payload and temporaries
   logic [57:0]       sq0_ff, sq0_in;
   logic [WIDE_W-1:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [10:0]       nk_ff, nk_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Serial unit
   cmd_type           cmd;
   logic [WIDE_W-1:0] opa, result;
   logic [OPB_W-1:0]  opb;
   logic              done;

   logic [28:0]       mag0, mag1;
   logic signed [33:0] sum_sel;
   logic [33:0]       sum_mag;
   logic [61:0]       sumsq_sel;
   logic [5:0]        d_blk, conv_next, sub_next;
   logic [27:0]       mean_q;
   logic [42:0]       root_inc;
   logic [41:0]       std_m;
   logic [26:0]       std_sat;
   logic              req_fire, csr_wr;

   mwsd_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .done   (done),
      .result (result)
   );

   // Register port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {26'd0, (csr_paddr[2] == REG_SUBSAMPLES) ? n_cfg_ff : k_cfg_ff};

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Selected channel and derived values
   always_comb begin
      mag0      = acc0_ff[28] ? 29'(-acc0_ff) : 29'(acc0_ff);
      mag1      = acc1_ff[28] ? 29'(-acc1_ff) : 29'(acc1_ff);
      sum_sel   = ch_ff ? sum1_ff : sum0_ff;
      sum_mag   = sum_sel[33] ? 34'(-sum_sel) : 34'(sum_sel);
      sumsq_sel = ch_ff ? sumsq1_ff : sumsq0_ff;
      d_blk     = (n_blk_ff > 6'd1) ? n_blk_ff - 6'd1 : 6'd1;
      conv_next = conv_cnt_ff + 6'd1;
      sub_next  = sub_cnt_ff + 6'd1;
      mean_q    = sum_sel[33] ? 28'(-result[27:0]) : result[27:0];
      root_inc  = {1'b0, result[41:0]} + 43'd1;
      std_m     = root_inc[42:1];
      std_sat   = (std_m > {15'd0, STD_MAX}) ? STD_MAX : std_m[26:0];
   end

   // Operand select for each step
   always_comb begin
      opa = '0;
      opb = '0;
      cmd.op = OP_MUL;
      cmd.start = (state_ff == ST_RUN);
      unique case (step_ff)
         SP_SQ0: begin
            opa = {55'd0, mag0};
            opb = {5'd0, mag0};
         end
         SP_SQ1: begin
            opa = {55'd0, mag1};
            opb = {5'd0, mag1};
         end
         SP_MN_150: begin
            opa = {50'd0, sum_mag};
            opb = MEAN_SCALE;
         end
         SP_MN_NK: begin
            opa = {78'd0, n_blk_ff};
            opb = {28'd0, k_lat_ff};
         end
         SP_MN_DIV: begin
            cmd.op = OP_DIV;
            opa = ta_ff + {70'd0, nk_ff, 3'd0};
            opb = {19'd0, nk_ff, 4'd0};
         end
         SP_SD_NQ: begin
            opa = {22'd0, sumsq_sel};
            opb = {28'd0, n_blk_ff};
         end
         SP_SD_S2: begin
            opa = {50'd0, sum_mag};
            opb = sum_mag;
         end
         SP_SD_NUM: begin
            opa = ta_ff;
            opb = STD_SCALE;
         end
         SP_SD_NKD: begin
            opa = {73'd0, nk_ff};
            opb = {28'd0, d_blk};
         end
         SP_SD_DEN: begin
            opa = tb_ff;
            opb = {28'd0, k_lat_ff};
         end
         SP_SD_DIV: begin
            cmd.op = OP_DIV;
            opa = ta_ff;
            opb = {8'd0, tb_ff[19:0], 6'd0};
         end
         SP_SD_SQRT: begin
            cmd.op = OP_SQRT;
            opa = ta_ff;
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      conv_cnt_in  = conv_cnt_ff;
      sub_cnt_in   = sub_cnt_ff;
      k_lat_in     = k_lat_ff;
      n_lat_in     = n_lat_ff;
      n_blk_in     = n_blk_ff;
      rsp_valid_in = rsp_valid_ff;
      acc0_in      = acc0_ff;
      acc1_in      = acc1_ff;
      sum0_in      = sum0_ff;
      sum1_in      = sum1_ff;
      sumsq0_in    = sumsq0_ff;
      sumsq1_in    = sumsq1_ff;
      sq0_in       = sq0_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      nk_in        = nk_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               acc0_in = acc0_ff + {{5{req_data.sample_ch0[23]}}, req_data.sample_ch0};
               acc1_in = acc1_ff + {{5{req_data.sample_ch1[23]}}, req_data.sample_ch1};
               k_lat_in = eff_count(k_cfg_ff);
               n_lat_in = eff_count(n_cfg_ff);
               if (conv_next >= eff_count(k_cfg_ff)) begin
                  conv_cnt_in = 6'd0;
                  step_in     = SP_SQ0;
                  state_in    = ST_RUN;
               end else begin
                  conv_cnt_in = conv_next;
               end
            end
         end
         ST_RUN: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (done) begin
               state_in = ST_RUN;
               unique case (step_ff)
                  SP_SQ0: begin
                     sq0_in  = result[57:0];
                     step_in = SP_SQ1;
                  end
                  SP_SQ1: begin
                     // close the sub-sample
                     sum0_in   = sum0_ff + {{5{acc0_ff[28]}}, acc0_ff};
                     sum1_in   = sum1_ff + {{5{acc1_ff[28]}}, acc1_ff};
                     sumsq0_in = sumsq0_ff + {4'd0, sq0_ff};
                     sumsq1_in = sumsq1_ff + {4'd0, result[57:0]};
                     acc0_in   = '0;
                     acc1_in   = '0;
                     sub_cnt_in = sub_next;
                     if (sub_next >= n_lat_ff) begin
                        n_blk_in = sub_next;
                        ch_in    = 1'b0;
                        step_in  = SP_MN_150;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  SP_MN_150: begin
                     ta_in   = result;
                     step_in = SP_MN_NK;
                  end
                  SP_MN_NK: begin
                     nk_in   = result[10:0];
                     step_in = SP_MN_DIV;
                  end
                  SP_MN_DIV: begin
                     if (ch_ff) res_in.mean_ch1_mv = mean_q;
                     else res_in.mean_ch0_mv = mean_q;
                     step_in = SP_SD_NQ;
                  end
                  SP_SD_NQ: begin
                     ta_in   = result;
                     step_in = SP_SD_S2;
                  end
                  SP_SD_S2: begin
                     if (result > ta_ff) begin
                        // negative variance clamps to zero
                        if (ch_ff) res_in.stddev_ch1_mv = '0;
                        else res_in.stddev_ch0_mv = '0;
                        if (ch_ff) begin
                           state_in = ST_OUT;
                        end else begin
                           ch_in   = 1'b1;
                           step_in = SP_MN_150;
                        end
                     end else begin
                        ta_in   = ta_ff - result;
                        step_in = SP_SD_NUM;
                     end
                  end
                  SP_SD_NUM: begin
                     ta_in   = result;
                     step_in = SP_SD_NKD;
                  end
                  SP_SD_NKD: begin
                     tb_in   = result;
                     step_in = SP_SD_DEN;
                  end
                  SP_SD_DEN: begin
                     tb_in   = result;
                     step_in = SP_SD_DIV;
                  end
                  SP_SD_DIV: begin
                     ta_in   = result;
                     step_in = SP_SD_SQRT;
                  end
                  SP_SD_SQRT: begin
                     if (ch_ff) res_in.stddev_ch1_mv = std_sat;
                     else res_in.stddev_ch0_mv = std_sat;
                     if (ch_ff) begin
                        state_in = ST_OUT;
                     end else begin
                        ch_in   = 1'b1;
                        step_in = SP_MN_150;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_OUT: begin
            // hand the block result to the output register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               sum0_in      = '0;
               sum1_in      = '0;
               sumsq0_in    = '0;
               sumsq1_in    = '0;
               sub_cnt_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff     <= 6'd15;
         n_cfg_ff     <= 6'd20;
         state_ff     <= ST_IDLE;
         step_ff      <= SP_SQ0;
         ch_ff        <= 1'b0;
         conv_cnt_ff  <= '0;
         sub_cnt_ff   <= '0;
         k_lat_ff     <= 6'd1;
         n_lat_ff     <= 6'd1;
         n_blk_ff     <= 6'd1;
         rsp_valid_ff <= 1'b0;
         acc0_ff      <= '0;
         acc1_ff      <= '0;
         sum0_ff      <= '0;
         sum1_ff      <= '0;
         sumsq0_ff    <= '0;
         sumsq1_ff    <= '0;
      end else begin
         if (csr_wr && csr_paddr[2] == REG_OVERSAMPLE) k_cfg_ff <= csr_pwdata[5:0];
         if (csr_wr && csr_paddr[2] == REG_SUBSAMPLES) n_cfg_ff <= csr_pwdata[5:0];
         state_ff     <= state_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         conv_cnt_ff  <= conv_cnt_in;
         sub_cnt_ff   <= sub_cnt_in;
         k_lat_ff     <= k_lat_in;
         n_lat_ff     <= n_lat_in;
         n_blk_ff     <= n_blk_in;
         rsp_valid_ff <= rsp_valid_in;
         acc0_ff      <= acc0_in;
         acc1_ff      <= acc1_in;
         sum0_ff      <= sum0_in;
         sum1_ff      <= sum1_in;
         sumsq0_ff    <= sumsq0_in;
         sumsq1_ff    <= sumsq1_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sq0_ff      <= sq0_in;
      ta_ff       <= ta_in;
      tb_ff       <= tb_in;
      nk_ff       <= nk_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- tb/sv/two_channel_block_mean_stddev_test.sv -----
// Testbench for two_channel_block_mean_stddev: streams random and edge-case ADC
// conversions, predicts block mean / stddev and checks every response in order.
// Depends on mwsd_pkg and the two_channel_block_mean_stddev RTL.
`timescale 1ns / 1ps

module two_channel_block_mean_stddev_test;
   import mwsd_pkg::*;

   localparam int  SETTLE_CYCLES = 1500;     // longer than one block-end computation
   localparam int  CYCLE_LIMIT   = 6000000;
   localparam int  HOLD_START    = 30000;    // receiver long hold-off starts after this
   localparam int  HOLD_CYCLES   = 8000;
   localparam int  HOLD_MIN_Q    = 40;       // pending requests to exceed before the hold starts
   localparam int  ITEM_TARGET   = 1250;
   localparam logic [2:0] ADDR_OVERSAMPLE = 3'd0;
   localparam logic [2:0] ADDR_SUBSAMPLES = 3'd4;
   localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] S_MIN = -24'sh800000;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   two_channel_block_mean_stddev u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predictor state, mirrors the block's registers and accumulators
   logic [5:0]         oversample_reg;
   logic [5:0]         subsample_reg;
   logic signed [63:0] os_acc0 = 0, os_acc1 = 0;
   int unsigned        conv_cnt = 0, sub_cnt = 0;
   logic signed [63:0] blk_sum0 = 0, blk_sum1 = 0;
   logic [127:0]       blk_sq0 = 0, blk_sq1 = 0;

   req_type     conversion_q[$];
   rsp_type     block_result_q[$];
   int          errors = 0;
   int unsigned cycle_cnt = 0;
   int          items_queued;

   function automatic logic [127:0] magnitude(input logic signed [63:0] v);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      return {64'd0, m};
   endfunction

   function automatic int unsigned eff_reg(input logic [5:0] v);
      if (v == 6'd0) return 1;
      if (v > 6'd32) return 32;
      return 32'(v);
   endfunction

   // Rounded block mean in Q16 mV, ties away from zero
   function automatic logic [27:0] block_mean(input logic signed [63:0] s,
                                              input int unsigned n, input int unsigned k);
      logic [127:0] den, q;
      den = 128'(n) * 128'(k) * 128'd8;
      q = (magnitude(s) * 128'd150 + den) / (den * 128'd2);
      if (s < 0) q = -q;
      return q[27:0];
   endfunction

   // Rounded sample stddev in Q16 mV, ties upward, saturating
   function automatic logic [26:0] block_stddev(input logic signed [63:0] s,
                                                input logic [127:0] sq,
                                                input int unsigned n, input int unsigned k);
      logic [127:0] nq, s2, num, den, t, lo, hi, mid;
      int unsigned  d;
      nq = sq * 128'(n);
      s2 = magnitude(s) * magnitude(s);
      if (s2 > nq) return 27'd0;
      d = (n > 1) ? n - 1 : 1;
      num = (nq - s2) * 128'd22500;
      den = 128'(n) * 128'(d) * 128'(k) * 128'(k) * 128'd64;
      lo = 0;
      hi = 128'(STD_MAX);
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (t * t * den <= num) lo = mid;
         else hi = mid - 1;
      end
      return lo[26:0];
   endfunction

   // Fold one accepted conversion into the predictor; queue a result at block end
   task automatic absorb_conversion(input req_type c);
      int unsigned k, n;
      rsp_type     r;
      k = eff_reg(oversample_reg);
      n = eff_reg(subsample_reg);
      os_acc0 += c.sample_ch0;
      os_acc1 += c.sample_ch1;
      conv_cnt++;
      if (conv_cnt < k) return;
      blk_sum0 += os_acc0;
      blk_sum1 += os_acc1;
      blk_sq0 += magnitude(os_acc0) * magnitude(os_acc0);
      blk_sq1 += magnitude(os_acc1) * magnitude(os_acc1);
      os_acc0 = 0;
      os_acc1 = 0;
      conv_cnt = 0;
      sub_cnt++;
      if (sub_cnt < n) return;
      r.mean_ch0_mv   = block_mean(blk_sum0, sub_cnt, k);
      r.stddev_ch0_mv = block_stddev(blk_sum0, blk_sq0, sub_cnt, k);
      r.mean_ch1_mv   = block_mean(blk_sum1, sub_cnt, k);
      r.stddev_ch1_mv = block_stddev(blk_sum1, blk_sq1, sub_cnt, k);
      block_result_q.push_back(r);
      blk_sum0 = 0;
      blk_sum1 = 0;
      blk_sq0 = 0;
      blk_sq1 = 0;
      sub_cnt = 0;
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request driver: bursts of random length with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) absorb_conversion(req_data);
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (conversion_q.size() > 0) begin
               req_data  <= conversion_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  case ($urandom_range(0, 3))
                     0:       gap_left = 0;
                     1:       gap_left = $urandom_range(1, 4);
                     2:       gap_left = $urandom_range(5, 80);
                     default: gap_left = $urandom_range(100, 900);
                  endcase
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: own stall pattern, one long hold-off, in-order check
   int stall_left;
   int stall_mode;
   int hold_left;
   bit hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
         stall_mode = 0;
         hold_left  = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (block_result_q.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = block_result_q.pop_front();
               if (rsp_data.mean_ch0_mv !== e.mean_ch0_mv) begin
                  $display("%0t: ch0 average exp %0d got %0d", $realtime,
                           e.mean_ch0_mv, rsp_data.mean_ch0_mv);
                  errors++;
               end
               if (rsp_data.stddev_ch0_mv !== e.stddev_ch0_mv) begin
                  $display("%0t: ch0 deviation exp %0d got %0d", $realtime,
                           e.stddev_ch0_mv, rsp_data.stddev_ch0_mv);
                  errors++;
               end
               if (rsp_data.mean_ch1_mv !== e.mean_ch1_mv) begin
                  $display("%0t: ch1 average exp %0d got %0d", $realtime,
                           e.mean_ch1_mv, rsp_data.mean_ch1_mv);
                  errors++;
               end
               if (rsp_data.stddev_ch1_mv !== e.stddev_ch1_mv) begin
                  $display("%0t: ch1 deviation exp %0d got %0d", $realtime,
                           e.stddev_ch1_mv, rsp_data.stddev_ch1_mv);
                  errors++;
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 3000);
         end else begin
            stall_left--;
         end
         // one long hold-off while plenty of requests are still pending
         if (!hold_done && cycle_cnt >= HOLD_START && conversion_q.size() > HOLD_MIN_Q) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_mode == 0)
            rsp_ready <= 1'b1;
         else if (stall_mode == 1)
            rsp_ready <= ($urandom_range(0, 3) != 0);
         else
            rsp_ready <= ($urandom_range(0, 9) == 0);
      end
   end

   // Register write: setup then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [5:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {26'($urandom_range(0, 32'h03FF_FFFF)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_OVERSAMPLE) oversample_reg = value;
      else subsample_reg = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_counts(input logic [5:0] k, input logic [5:0] n);
      csr_write(ADDR_OVERSAMPLE, k);
      csr_write(ADDR_SUBSAMPLES, n);
   endtask

   task automatic push_pair(input logic signed [23:0] a, input logic signed [23:0] b);
      req_type c;
      c.sample_ch0 = a;
      c.sample_ch1 = b;
      conversion_q.push_back(c);
      items_queued++;
   endtask

   // Random sample: full range, rail values or a noisy level
   function automatic logic signed [23:0] rand_sample(input logic signed [23:0] level);
      case ($urandom_range(0, 5))
         0:       return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
         1:       return level;
         2, 3:    return level + 24'($signed($urandom_range(0, 64)) - 32);
         default: return 24'($urandom);
      endcase
   endfunction

   // Wait for the block to drain all work before touching registers
   task automatic wait_idle();
      while (conversion_q.size() != 0 || req_valid || block_result_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus sequence
   initial begin
      logic signed [23:0] lvl0, lvl1;
      int                 cnt;
      items_queued = 0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      oversample_reg = 6'd15;
      subsample_reg = 6'd20;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset counts, partial sub-sample, then counts lowered mid-way
      for (int i = 0; i < 10; i++) push_pair(rand_sample(24'sd1000), rand_sample(-24'sd5000));
      wait_idle();
      set_counts(6'd1, 6'd1);
      push_pair(S_MAX, S_MIN);
      push_pair(S_MIN, S_MAX);
      push_pair(24'sd0, 24'sd0);
      push_pair(-24'sd1, 24'sd1);
      wait_idle();
      // Zero counts act as one
      set_counts(6'd0, 6'd0);
      push_pair(24'sd3, -24'sd3);
      push_pair(S_MAX, S_MAX);
      wait_idle();
      // Rail-to-rail swing over two sub-samples, and a constant block
      set_counts(6'd1, 6'd2);
      push_pair(S_MAX, S_MIN);
      push_pair(S_MIN, S_MAX);
      push_pair(S_MIN, S_MIN);
      push_pair(S_MIN, S_MIN);
      wait_idle();

      // Largest counts; values above the maximum act as the maximum
      set_counts(6'd63, 6'd1);
      for (int i = 0; i < 32; i++) push_pair(S_MAX, S_MIN);
      wait_idle();
      set_counts(6'd1, 6'd33);
      for (int i = 0; i < 32; i++)
         push_pair((i % 2) ? S_MAX : S_MIN, rand_sample(24'sd0));
      wait_idle();
      set_counts(6'd32, 6'd2);
      for (int i = 0; i < 64; i++) push_pair(rand_sample(S_MAX), rand_sample(S_MIN));
      wait_idle();

      // Random phases, mostly small counts
      while (items_queued < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            set_counts(6'($urandom_range(0, 63)), 6'($urandom_range(0, 3)));
         else
            set_counts(6'($urandom_range(0, 5)), 6'($urandom_range(0, 6)));
         lvl0 = 24'($urandom);
         lvl1 = 24'($urandom);
         cnt = $urandom_range(20, 90);
         for (int i = 0; i < cnt; i++) push_pair(rand_sample(lvl0), rand_sample(lvl1));
         wait_idle();
      end

      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
